// File: src/bmhq_pkg.sv
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared sizes, codes and controller types for the max-heap priority queue.
// ----------------------------------------------------------------------------
package bmhq_pkg;

	localparam int CAPACITY = 1024;
	localparam int VAL_W    = 31;
	localparam int DATA_W   = 32;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int KID_W    = CNT_W + 1;

	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	typedef enum logic [1:0] {
		ST_POPPED = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_FULL   = 2'd2
	} status_t;

	localparam logic FUNC_PUSH = 1'b0;
	localparam logic FUNC_POP  = 1'b1;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_PUSH_INIT,
		OP_RD_PARENT,
		OP_WR_PARENT,
		OP_WR_VAL,
		OP_RD_ENDS,
		OP_POP_INIT,
		OP_RD_KIDS,
		OP_WR_CHILD,
		OP_EMIT
	} op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PUSH_INIT,
		S_PUSH_CHK,
		S_PUSH_CMP,
		S_POP_ENDS,
		S_POP_INIT,
		S_POP_CHK,
		S_POP_CMP,
		S_EMIT_POP,
		S_EMIT_EMPTY,
		S_EMIT_FULL
	} state_t;

	typedef struct packed {
		op_t     op;
		status_t code;
	} cmd_t;

	typedef struct packed {
		logic is_full;
		logic is_empty;
		logic at_root;
		logic push_gt;
		logic kid_out;
		logic pop_stop;
		logic out_free;
	} stat_t;

	// one-based slot to RAM address
	function automatic logic [ADDR_W-1:0] slot_addr(input logic [KID_W-1:0] slot);
		logic [KID_W-1:0] tmp;
		tmp = slot - KID_W'(1);
		return tmp[ADDR_W-1:0];
	endfunction

endpackage

// File: src/binary_max_heap_queue_top.sv
// ----------------------------------------------------------------------------
// binary_max_heap_queue_top
// Max-heap priority queue over a 1024-entry two-read-port RAM.
// Push: sift-up from the new last slot, moving smaller parents down a level; no beat.
// Pop: moves the last value to the root, sifts it down, emits the old root as the beat.
// Full/empty rejects: zero-value beat; every beat waits for a free output register.
// One item at a time; input waits on the walk (one RAM read, one compare per level).
// Reset empties the queue at once; the output register holds one waiting beat.
// ----------------------------------------------------------------------------
module binary_max_heap_queue_top
	import bmhq_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [DATA_W-1:0] s_axis_tdata,  // [30:0] value
	input  logic              s_axis_tuser,  // [0] func
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [DATA_W-1:0] m_axis_tdata,  // [30:0] max_value
	output logic [1:0]        m_axis_tuser   // [1:0] status
);

	cmd_t             cmd;
	stat_t            stat;
	logic [VAL_W-1:0] out_value;

	bmhq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_func  (s_axis_tuser),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	bmhq_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_value   (s_axis_tdata[VAL_W-1:0]),
		.cmd        (cmd),
		.stat       (stat),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_status (m_axis_tuser),
		.out_value  (out_value)
	);

	assign m_axis_tdata = {{(DATA_W-VAL_W){1'b0}}, out_value};

endmodule

// File: src/bmhq_ram.sv
// ----------------------------------------------------------------------------
// bmhq_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module bmhq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

// File: src/bmhq_ctrl.sv
// ----------------------------------------------------------------------------
// bmhq_ctrl
// Sequencer for push sift-up and pop sift-down walks over the heap store.
// ----------------------------------------------------------------------------
module bmhq_ctrl
	import bmhq_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  logic  in_func,
	output logic  in_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd.op   = OP_NONE;
		cmd.code = ST_POPPED;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op = OP_LOAD;
					if (in_func == FUNC_PUSH) begin
						state_d = stat.is_full ? S_EMIT_FULL : S_PUSH_INIT;
					end else begin
						state_d = stat.is_empty ? S_EMIT_EMPTY : S_POP_ENDS;
					end
				end
			end
			S_PUSH_INIT: begin
				cmd.op  = OP_PUSH_INIT;
				state_d = S_PUSH_CHK;
			end
			S_PUSH_CHK: begin
				if (stat.at_root) begin
					cmd.op  = OP_WR_VAL;
					state_d = S_IDLE;
				end else begin
					cmd.op  = OP_RD_PARENT;
					state_d = S_PUSH_CMP;
				end
			end
			S_PUSH_CMP: begin
				if (stat.push_gt) begin
					cmd.op  = OP_WR_PARENT;
					state_d = S_PUSH_CHK;
				end else begin
					cmd.op  = OP_WR_VAL;
					state_d = S_IDLE;
				end
			end
			S_POP_ENDS: begin
				cmd.op  = OP_RD_ENDS;
				state_d = S_POP_INIT;
			end
			S_POP_INIT: begin
				cmd.op  = OP_POP_INIT;
				state_d = S_POP_CHK;
			end
			S_POP_CHK: begin
				if (stat.kid_out) begin
					cmd.op  = OP_WR_VAL;
					state_d = S_EMIT_POP;
				end else begin
					cmd.op  = OP_RD_KIDS;
					state_d = S_POP_CMP;
				end
			end
			S_POP_CMP: begin
				if (stat.pop_stop) begin
					cmd.op  = OP_WR_VAL;
					state_d = S_EMIT_POP;
				end else begin
					cmd.op  = OP_WR_CHILD;
					state_d = S_POP_CHK;
				end
			end
			S_EMIT_POP, S_EMIT_EMPTY, S_EMIT_FULL: begin
				cmd.code = (state_q == S_EMIT_POP)   ? ST_POPPED :
				           (state_q == S_EMIT_EMPTY) ? ST_EMPTY  : ST_FULL;
				if (stat.out_free) begin
					cmd.op  = OP_EMIT;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// File: src/bmhq_dp.sv
// ----------------------------------------------------------------------------
// bmhq_dp
// Heap store, walk registers, compares and the output register.
// ----------------------------------------------------------------------------
module bmhq_dp
	import bmhq_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [VAL_W-1:0]  in_value,
	input  cmd_t              cmd,
	output stat_t             stat,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        out_status,
	output logic [VAL_W-1:0]  out_value
);

	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  pos_q;
	logic [KID_W-1:0]  kid_q;
	logic [VAL_W-1:0]  val_q;
	logic [VAL_W-1:0]  top_q;

	logic              out_valid_q;
	logic [1:0]        out_status_q;
	logic [VAL_W-1:0]  out_value_q;

	logic [VAL_W-1:0]  rd_a, rd_b;
	logic [ADDR_W-1:0] raddr_a, raddr_b, waddr;
	logic [VAL_W-1:0]  wdata;
	logic              we;

	logic [KID_W-1:0]  pos_ext, cnt_ext, kid_nxt;
	logic              take_right;
	logic [KID_W-1:0]  child;
	logic [VAL_W-1:0]  child_val;

	assign pos_ext    = {1'b0, pos_q};
	assign cnt_ext    = {1'b0, count_q};
	assign kid_nxt    = kid_q + KID_W'(1);
	assign take_right = (kid_q < cnt_ext) && (rd_a < rd_b);
	assign child      = take_right ? kid_nxt : kid_q;
	assign child_val  = take_right ? rd_b : rd_a;

	always_comb begin
		raddr_a = '0;
		raddr_b = '0;
		waddr   = slot_addr(pos_ext);
		wdata   = val_q;
		we      = 1'b0;
		unique case (cmd.op)
			OP_RD_PARENT: raddr_a = slot_addr(pos_ext >> 1);
			OP_RD_ENDS: begin
				raddr_a = slot_addr(KID_W'(1));
				raddr_b = slot_addr(cnt_ext);
			end
			OP_RD_KIDS: begin
				raddr_a = slot_addr(kid_q);
				raddr_b = slot_addr(kid_nxt);
			end
			OP_WR_VAL: we = 1'b1;
			OP_WR_PARENT: begin
				we    = 1'b1;
				wdata = rd_a;
			end
			OP_WR_CHILD: begin
				we    = 1'b1;
				wdata = child_val;
			end
			default: ;
		endcase
	end

	bmhq_ram #(
		.WIDTH (VAL_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (raddr_a),
		.rdata_a (rd_a),
		.raddr_b (raddr_b),
		.rdata_b (rd_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.op == OP_PUSH_INIT) begin
			count_q <= count_q + CNT_W'(1);
		end else if (cmd.op == OP_POP_INIT) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD:      val_q <= in_value;
			OP_PUSH_INIT: pos_q <= count_q + CNT_W'(1);
			OP_WR_PARENT: pos_q <= pos_q >> 1;
			OP_POP_INIT: begin
				top_q <= rd_a;
				val_q <= rd_b;
				pos_q <= CNT_W'(1);
				kid_q <= KID_W'(2);
			end
			OP_WR_CHILD: begin
				pos_q <= child[CNT_W-1:0];
				kid_q <= child << 1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == OP_EMIT) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_EMIT) begin
			out_status_q <= cmd.code;
			out_value_q  <= (cmd.code == ST_POPPED) ? top_q : '0;
		end
	end

	assign stat.is_full  = (count_q == CAP_CNT);
	assign stat.is_empty = (count_q == '0);
	assign stat.at_root  = (pos_q == CNT_W'(1));
	assign stat.push_gt  = (val_q > rd_a);
	assign stat.kid_out  = (kid_q > cnt_ext);
	assign stat.pop_stop = (val_q > child_val);
	assign stat.out_free = !out_valid_q || out_ready;

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_value  = out_value_q;

endmodule

// File: src/bmhq_checker.sv
// ----------------------------------------------------------------------------
// bmhq_checker
// Port-level checks for the max-heap priority queue.
// ----------------------------------------------------------------------------
module bmhq_checker
	import bmhq_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              s_axis_tvalid,
	input logic              s_axis_tready,
	input logic [DATA_W-1:0] s_axis_tdata,
	input logic              s_axis_tuser,
	input logic              m_axis_tvalid,
	input logic              m_axis_tready,
	input logic [DATA_W-1:0] m_axis_tdata,
	input logic [1:0]        m_axis_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("output beat changed while stalled");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != ST_POPPED) |-> m_axis_tdata == '0)
		else $error("reject beat carries a value");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while an item is in progress");

	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
		else $error("result beat too soon after acceptance");

endmodule

bind binary_max_heap_queue_top bmhq_checker u_bmhq_checker (.*);
